>>> rtl/xzcp_pkg.sv
// Package for the xz circle push-out block: shared widths and constants.
// Used by the channel interfaces, the top level and the checker.
package xzcp_pkg;

    localparam int XZCP_COORD_BITS = 32;
    localparam int XZCP_SQRT_GUARD = 15;

endpackage

>>> rtl/xzcp_in_if.sv
// Input channel of the push-out block: one pair of bodies per transfer.
// Depends on xzcp_pkg for the default coordinate width.
interface xzcp_in_if import xzcp_pkg::*; #(
    parameter int COORD_BITS = XZCP_COORD_BITS
);
    logic                         valid;
    logic                         ready;
    logic                         use_height;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic        [COORD_BITS-2:0] a_radius;
    logic        [COORD_BITS-2:0] a_height;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic        [COORD_BITS-2:0] b_radius;
    logic        [COORD_BITS-2:0] b_height;

    modport source (output valid, use_height, a_x, a_y, a_z, a_radius, a_height,
                    b_x, b_y, b_z, b_radius, b_height, input ready);
    modport sink (input valid, use_height, a_x, a_y, a_z, a_radius, a_height,
                  b_x, b_y, b_z, b_radius, b_height, output ready);
endinterface

interface xzcp_out_if import xzcp_pkg::*; #(
    parameter int COORD_BITS = XZCP_COORD_BITS
);
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;

    modport source (output valid, hit, out_x, out_y, out_z, input ready);
    modport sink (input valid, hit, out_x, out_y, out_z, output ready);
endinterface

>>> rtl/xzcp_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Standalone unit; stage enable comes from the owner's pipeline control.
module xzcp_sqrt #(
    parameter int ROOT_BITS = 46
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [2*ROOT_BITS-1:0]   i_rad,
    output logic [ROOT_BITS-1:0]     o_root
);
    localparam int RW = 2 * ROOT_BITS;

    logic [RW-1:0]        w_rem  [0:ROOT_BITS];
    logic [ROOT_BITS-1:0] w_root [0:ROOT_BITS];

    assign w_rem[0]  = i_rad;
    assign w_root[0] = '0;

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
        localparam int B = ROOT_BITS - 1 - k;
        logic [RW:0]          trial;
        logic [RW-1:0]        r_rem;
        logic [RW-1:0]        n_rem;
        logic [ROOT_BITS-1:0] r_root;
        logic [ROOT_BITS-1:0] n_root;

        always_comb begin
            trial = ((RW+1)'(w_root[k]) << (B + 1)) | ((RW+1)'(1) << (2 * B));
            n_rem  = w_rem[k];
            n_root = w_root[k];
            if ({1'b0, w_rem[k]} >= trial) begin
                n_rem  = w_rem[k] - trial[RW-1:0];
                n_root = w_root[k] | (ROOT_BITS'(1) << B);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_root <= n_root;
            end
        end

        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
    end

    assign o_root = w_root[ROOT_BITS];
endmodule

>>> rtl/xzcp_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Caller keeps the quotient below 2^QUO_BITS; enable comes from the owner.
module xzcp_div #(
    parameter int DEN_BITS = 46,
    parameter int QUO_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [DEN_BITS+QUO_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0]          i_den,
    output logic [QUO_BITS-1:0]          o_quo
);
    localparam int CW = DEN_BITS + QUO_BITS;

    logic [CW-1:0]       w_rem [0:QUO_BITS];
    logic [DEN_BITS-1:0] w_den [0:QUO_BITS];
    logic [QUO_BITS-1:0] w_quo [0:QUO_BITS];

    assign w_rem[0] = i_num;
    assign w_den[0] = i_den;
    assign w_quo[0] = '0;

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
        localparam int I = QUO_BITS - 1 - k;
        logic [CW-1:0]       trial;
        logic [CW-1:0]       r_rem;
        logic [CW-1:0]       n_rem;
        logic [DEN_BITS-1:0] r_den;
        logic [QUO_BITS-1:0] r_quo;
        logic [QUO_BITS-1:0] n_quo;

        always_comb begin
            trial = CW'(w_den[k]) << I;
            n_rem = w_rem[k];
            n_quo = w_quo[k];
            if (w_rem[k] >= trial) begin
                n_rem = w_rem[k] - trial;
                n_quo = w_quo[k] | (QUO_BITS'(1) << I);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_rem;
                r_den <= w_den[k];
                r_quo <= n_quo;
            end
        end

        assign w_rem[k+1] = r_rem;
        assign w_den[k+1] = r_den;
        assign w_quo[k+1] = r_quo;
    end

    assign o_quo = w_quo[QUO_BITS];
endmodule

>>> rtl/xz_circle_pushout.sv
// Cylinder/sphere push-out between bodies A and B in the xz plane, Q16.16.
// Depends on xzcp_pkg, xzcp_in_if/xzcp_out_if, xzcp_sqrt and xzcp_div.
//
// Fully pipelined: one pair is taken every cycle unless the pipe holds, and each
// result passes stages 0 to 3, the square root, stage 4, the dividers and stage 5.
// The pipe is made long by the bit-per-stage square root (COORD_BITS + 14 stages)
// followed by the bit-per-stage dividers (COORD_BITS stages). The whole pipe
// holds while a finished result waits at the output, so input ready follows
// output ready when the last stage is full.
module xz_circle_pushout import xzcp_pkg::*; #(
    parameter int COORD_BITS = XZCP_COORD_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    xzcp_in_if.sink    i_in,
    xzcp_out_if.source o_out
);
    localparam int W  = COORD_BITS;
    localparam int G  = XZCP_SQRT_GUARD;
    localparam int SQ = W - 1 + G;
    localparam int Q  = W;
    localparam int CW = SQ + Q;
    localparam int L  = 6 + SQ + Q;
    localparam int SD = SQ + Q + 2;

    typedef struct packed {
        logic                hit;
        logic                zero;
        logic                sx;
        logic                sz;
        logic [W-2:0]        r;
        logic signed [W-1:0] ax;
        logic signed [W-1:0] az;
        logic signed [W-1:0] bx;
        logic signed [W-1:0] by;
        logic signed [W-1:0] bz;
    } t_side;

    typedef struct packed {
        logic [2*W-3:0] nx;
        logic [2*W-3:0] nz;
    } t_num;

    logic         en;
    logic [L-1:0] r_vld;

    assign en         = !r_vld[L-1] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[L-2:0], i_in.valid};
        end
    end

    // stage 0: input register
    logic                r0_uh;
    logic signed [W-1:0] r0_ax, r0_ay, r0_az, r0_bx, r0_by, r0_bz;
    logic        [W-2:0] r0_ar, r0_ah, r0_br, r0_bh;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_uh <= i_in.use_height;
            r0_ax <= i_in.a_x;
            r0_ay <= i_in.a_y;
            r0_az <= i_in.a_z;
            r0_ar <= i_in.a_radius;
            r0_ah <= i_in.a_height;
            r0_bx <= i_in.b_x;
            r0_by <= i_in.b_y;
            r0_bz <= i_in.b_z;
            r0_br <= i_in.b_radius;
            r0_bh <= i_in.b_height;
        end
    end

    // stage 1: deltas, radius sum, vertical span test
    logic signed [W:0] dx1, dz1, atop1, btop1;
    logic        [W-1:0] rsum1;
    logic        [W:0] r1_adx, r1_adz;
    logic        [W-2:0] r1_r;
    logic        r1_sx, r1_sz, r1_hok;
    logic signed [W-1:0] r1_ax, r1_az, r1_bx, r1_by, r1_bz;

    always_comb begin
        dx1   = $signed({r0_bx[W-1], r0_bx}) - $signed({r0_ax[W-1], r0_ax});
        dz1   = $signed({r0_bz[W-1], r0_bz}) - $signed({r0_az[W-1], r0_az});
        btop1 = $signed({r0_by[W-1], r0_by}) + $signed({2'b00, r0_bh});
        atop1 = $signed({r0_ay[W-1], r0_ay}) + $signed({2'b00, r0_ah});
        rsum1 = W'(r0_ar) + W'(r0_br);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_adx <= dx1[W] ? (W+1)'(-dx1) : (W+1)'(dx1);
            r1_adz <= dz1[W] ? (W+1)'(-dz1) : (W+1)'(dz1);
            r1_sx  <= dx1[W];
            r1_sz  <= dz1[W];
            r1_r   <= rsum1[W-1] ? {(W-1){1'b1}} : rsum1[W-2:0];
            r1_hok <= !r0_uh || (!($signed({r0_ay[W-1], r0_ay}) > btop1)
                                 && !(atop1 < $signed({r0_by[W-1], r0_by})));
            r1_ax  <= r0_ax;
            r1_az  <= r0_az;
            r1_bx  <= r0_bx;
            r1_by  <= r0_by;
            r1_bz  <= r0_bz;
        end
    end

    // stage 2: squares and push-out numerators
    logic [2*W+1:0] r2_sqx, r2_sqz;
    logic [2*W-3:0] r2_rr;
    t_num           r2_num;
    logic           r2_sx, r2_sz, r2_hok;
    logic [W-2:0]   r2_r;
    logic signed [W-1:0] r2_ax, r2_az, r2_bx, r2_by, r2_bz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sqx    <= r1_adx * r1_adx;
            r2_sqz    <= r1_adz * r1_adz;
            r2_rr     <= r1_r * r1_r;
            r2_num.nx <= r1_adx[W-2:0] * r1_r;
            r2_num.nz <= r1_adz[W-2:0] * r1_r;
            r2_sx     <= r1_sx;
            r2_sz     <= r1_sz;
            r2_hok    <= r1_hok;
            r2_r      <= r1_r;
            r2_ax     <= r1_ax;
            r2_az     <= r1_az;
            r2_bx     <= r1_bx;
            r2_by     <= r1_by;
            r2_bz     <= r1_bz;
        end
    end

    // stage 3: distance test
    logic [2*W+1:0]  s3;
    t_side           n_side;
    logic [2*SQ-1:0] r3_rad;

    always_comb begin
        s3          = r2_sqx + r2_sqz;
        n_side.hit  = r2_hok && (s3 <= (2*W+2)'(r2_rr));
        n_side.zero = (s3 == '0);
        n_side.sx   = r2_sx;
        n_side.sz   = r2_sz;
        n_side.r    = r2_r;
        n_side.ax   = r2_ax;
        n_side.az   = r2_az;
        n_side.bx   = r2_bx;
        n_side.by   = r2_by;
        n_side.bz   = r2_bz;
    end

    t_side r_sd [0:SD-1];
    t_num  r_nd [0:SQ];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_rad  <= {s3[2*W-3:0], {(2*G){1'b0}}};
            r_sd[0] <= n_side;
            r_nd[0] <= r2_num;
            for (int k = 1; k < SD; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            for (int k = 1; k <= SQ; k++) begin
                r_nd[k] <= r_nd[k-1];
            end
        end
    end

    logic [SQ-1:0] dg;

    xzcp_sqrt #(.ROOT_BITS(SQ)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r3_rad),
        .o_root (dg)
    );

    // stage 4: rounded numerators
    logic [CW-1:0] r4_numx, r4_numz;
    logic [SQ-1:0] r4_den;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_numx <= CW'({r_nd[SQ].nx, {G{1'b0}}}) + CW'(dg >> 1);
            r4_numz <= CW'({r_nd[SQ].nz, {G{1'b0}}}) + CW'(dg >> 1);
            r4_den  <= dg;
        end
    end

    logic [Q-1:0] qx, qz;

    xzcp_div #(.DEN_BITS(SQ), .QUO_BITS(Q)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r4_numx),
        .i_den (r4_den),
        .o_quo (qx)
    );

    xzcp_div #(.DEN_BITS(SQ), .QUO_BITS(Q)) u_div_z (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r4_numz),
        .i_den (r4_den),
        .o_quo (qz)
    );

    // stage 5: apply offsets, saturate, output register
    t_side               sd5;
    logic [W-1:0]        offx5, offz5;
    logic signed [W+1:0] sumx5, sumz5;
    logic signed [W-1:0] ox5, oz5;
    logic                r5_hit;
    logic signed [W-1:0] r5_x, r5_y, r5_z;

    always_comb begin
        sd5   = r_sd[SD-1];
        offx5 = sd5.zero ? W'(sd5.r) : qx;
        offz5 = sd5.zero ? '0 : qz;
        sumx5 = $signed({{2{sd5.ax[W-1]}}, sd5.ax})
              + (sd5.sx ? -$signed({2'b00, offx5}) : $signed({2'b00, offx5}));
        sumz5 = $signed({{2{sd5.az[W-1]}}, sd5.az})
              + (sd5.sz ? -$signed({2'b00, offz5}) : $signed({2'b00, offz5}));
        if (sumx5[W+1:W-1] == '0 || sumx5[W+1:W-1] == '1) begin
            ox5 = sumx5[W-1:0];
        end else begin
            ox5 = sumx5[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        if (sumz5[W+1:W-1] == '0 || sumz5[W+1:W-1] == '1) begin
            oz5 = sumz5[W-1:0];
        end else begin
            oz5 = sumz5[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_hit <= sd5.hit;
            r5_x   <= sd5.hit ? ox5 : sd5.bx;
            r5_y   <= sd5.by;
            r5_z   <= sd5.hit ? oz5 : sd5.bz;
        end
    end

    assign o_out.valid = r_vld[L-1];
    assign o_out.hit   = r5_hit;
    assign o_out.out_x = r5_x;
    assign o_out.out_y = r5_y;
    assign o_out.out_z = r5_z;
endmodule

>>> rtl/xzcp_check.sv
// Port-level checker for xz_circle_pushout, attached by the bind below.
// Depends on xzcp_pkg for the default coordinate width.
module xzcp_check import xzcp_pkg::*; #(
    parameter int COORD_BITS = XZCP_COORD_BITS
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic                  i_out_hit,
    input logic [COORD_BITS-1:0] i_out_x,
    input logic [COORD_BITS-1:0] i_out_y,
    input logic [COORD_BITS-1:0] i_out_z
);
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result presented right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("stalled result dropped");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable({i_out_hit, i_out_x, i_out_y, i_out_z}))
        else $error("stalled result changed");
endmodule

bind xz_circle_pushout xzcp_check #(.COORD_BITS(COORD_BITS)) u_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_hit   (o_out.hit),
    .i_out_x     (o_out.out_x),
    .i_out_y     (o_out.out_y),
    .i_out_z     (o_out.out_z)
);
